### rtl/sab_pkg.sv
// Package for the stereo band limiter and Haas widener.
// Holds sample and coefficient types, register indexes, sequencer codes and the step program.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package sab_pkg;

  // Fixed formats of the sample and coefficient fields.
  localparam int unsigned SAMPLE_BITS       = 24;
  localparam int unsigned COEF_FRAC_BITS    = 16;
  localparam int unsigned COEF_BITS         = 18;
  localparam int unsigned GAIN_BITS         = 17;
  localparam int unsigned DLEN_BITS         = 12;
  localparam int unsigned CFG_DATA_BITS     = 18;
  localparam int unsigned CFG_INDEX_BITS    = 3;
  localparam int unsigned PROD_BITS         = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned ACC_BITS          = PROD_BITS + 3;
  localparam int unsigned MAX_DELAY_DEFAULT = 2048;

  // Sequencer program length and the step at which the delay read is taken.
  localparam int unsigned NUM_STEPS         = 16;
  localparam int unsigned STEP_BITS         = 5;
  localparam int unsigned RUN_LAST          = NUM_STEPS + 1;
  localparam int unsigned DLY_CAPTURE_STEP  = 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  // Unity gain and rounding / saturation constants.
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(64'd1 << COEF_FRAC_BITS);
  localparam logic signed [ACC_BITS-1:0] ACC_HALF =
    ACC_BITS'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_BITS-1:0] SAT_MAX =
    ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_BITS-1:0] SAT_MIN = -SAT_MAX - ACC_BITS'(1);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIX_GAIN     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HP_GAIN      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HP_FEEDBACK  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LP_GAIN      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LP_FEEDBACK  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_LENGTH = 3'd6;

  // Register reset values.
  localparam logic                        RST_ENABLE       = 1'b0;
  localparam logic [GAIN_BITS-1:0]        RST_MIX_GAIN     = 17'd32768;
  localparam logic [GAIN_BITS-1:0]        RST_HP_GAIN      = 17'd65536;
  localparam logic signed [COEF_BITS-1:0] RST_HP_FEEDBACK  = '0;
  localparam logic [GAIN_BITS-1:0]        RST_LP_GAIN      = 17'd65536;
  localparam logic signed [COEF_BITS-1:0] RST_LP_FEEDBACK  = '0;
  localparam logic [DLEN_BITS-1:0]        RST_DELAY_LENGTH = 12'd360;

  // Channel payloads.
  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
    logic    last_frame;
  } in_item_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
    logic    last_frame_out;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  // Sample-side operand of the shared multiplier.
  typedef enum logic [3:0] {
    OPA_IN_L,
    OPA_IN_R,
    OPA_X1_HPL,
    OPA_X1_HPR,
    OPA_X1_LPL,
    OPA_X1_LPR,
    OPA_Y1_HPL,
    OPA_Y1_HPR,
    OPA_Y1_LPL,
    OPA_Y1_LPR,
    OPA_WET_R
  } opa_t;

  // Coefficient-side operand of the shared multiplier.
  typedef enum logic [2:0] {
    OPB_HP_B0,
    OPB_HP_B1,
    OPB_HP_A1,
    OPB_LP_B0,
    OPB_LP_A1,
    OPB_DRY,
    OPB_WET
  } opb_t;

  // Where a finished sum is written.
  typedef enum logic [2:0] {
    DST_NONE,
    DST_HP_L,
    DST_HP_R,
    DST_LP_L,
    DST_LP_R,
    DST_OUT_L,
    DST_OUT_R
  } dest_t;

  // Accumulator control that travels with a product.
  typedef struct packed {
    logic  first;
    logic  last;
    dest_t dest;
  } mac_ctl_t;

  // One step of the program.
  typedef struct packed {
    opa_t     opa;
    opb_t     opb;
    mac_ctl_t mac;
  } step_ctl_t;

  // Sequencer to datapath control group.
  typedef struct packed {
    logic      accept;
    logic      dly_capture;
    logic      out_load;
    step_ctl_t op;
  } seq_ctl_t;

  localparam mac_ctl_t MAC_IDLE = '{first: 1'b0, last: 1'b0, dest: DST_NONE};

  function automatic step_ctl_t step_entry(input opa_t a, input opb_t b, input logic first,
                                           input logic last, input dest_t dest);
    step_ctl_t c;
    c.opa       = a;
    c.opb       = b;
    c.mac.first = first;
    c.mac.last  = last;
    c.mac.dest  = dest;
    return c;
  endfunction

  // Program: four three-term filters, then two two-term mixes.
  function automatic step_ctl_t step_program(input logic [STEP_BITS-1:0] step);
    step_ctl_t c;
    c = '{opa: OPA_IN_L, opb: OPB_HP_B0, mac: MAC_IDLE};
    case (step)
      5'd0:  c = step_entry(OPA_IN_L,   OPB_HP_B0, 1'b1, 1'b0, DST_NONE);
      5'd1:  c = step_entry(OPA_X1_HPL, OPB_HP_B1, 1'b0, 1'b0, DST_NONE);
      5'd2:  c = step_entry(OPA_Y1_HPL, OPB_HP_A1, 1'b0, 1'b1, DST_HP_L);
      5'd3:  c = step_entry(OPA_IN_R,   OPB_HP_B0, 1'b1, 1'b0, DST_NONE);
      5'd4:  c = step_entry(OPA_X1_HPR, OPB_HP_B1, 1'b0, 1'b0, DST_NONE);
      5'd5:  c = step_entry(OPA_Y1_HPR, OPB_HP_A1, 1'b0, 1'b1, DST_HP_R);
      5'd6:  c = step_entry(OPA_Y1_HPL, OPB_LP_B0, 1'b1, 1'b0, DST_NONE);
      5'd7:  c = step_entry(OPA_X1_LPL, OPB_LP_B0, 1'b0, 1'b0, DST_NONE);
      5'd8:  c = step_entry(OPA_Y1_LPL, OPB_LP_A1, 1'b0, 1'b1, DST_LP_L);
      5'd9:  c = step_entry(OPA_Y1_HPR, OPB_LP_B0, 1'b1, 1'b0, DST_NONE);
      5'd10: c = step_entry(OPA_X1_LPR, OPB_LP_B0, 1'b0, 1'b0, DST_NONE);
      5'd11: c = step_entry(OPA_Y1_LPR, OPB_LP_A1, 1'b0, 1'b1, DST_LP_R);
      5'd12: c = step_entry(OPA_IN_L,   OPB_DRY,   1'b1, 1'b0, DST_NONE);
      5'd13: c = step_entry(OPA_Y1_LPL, OPB_WET,   1'b0, 1'b1, DST_OUT_L);
      5'd14: c = step_entry(OPA_IN_R,   OPB_DRY,   1'b1, 1'b0, DST_NONE);
      5'd15: c = step_entry(OPA_WET_R,  OPB_WET,   1'b0, 1'b1, DST_OUT_R);
      default: c = '{opa: OPA_IN_L, opb: OPB_HP_B0, mac: MAC_IDLE};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/sab_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on sab_pkg for default sizes only.
`timescale 1ns / 1ps
`default_nettype none

module sab_ram #(
  parameter int unsigned WIDTH = sab_pkg::SAMPLE_BITS,
  parameter int unsigned DEPTH = sab_pkg::MAX_DELAY_DEFAULT,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/sab_mac.sv
// Shared multiply-accumulate unit with rounding and saturation of the finished sum.
// Depends on sab_pkg for sample, coefficient and control types.
`timescale 1ns / 1ps
`default_nettype none

module sab_mac (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sab_pkg::sample_t    a,
  input  wire sab_pkg::coef_t      b,
  input  wire sab_pkg::mac_ctl_t   ctl,
  output sab_pkg::sample_t         res,
  output sab_pkg::dest_t           res_dest
);

  logic signed [sab_pkg::PROD_BITS-1:0] prod_r;
  logic signed [sab_pkg::ACC_BITS-1:0]  acc_r;
  logic signed [sab_pkg::ACC_BITS-1:0]  acc_rnd;
  logic signed [sab_pkg::ACC_BITS-1:0]  prod_ext;
  sab_pkg::mac_ctl_t                    c1_r;
  sab_pkg::mac_ctl_t                    c2_r;

  // Control travels alongside the product and the sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= sab_pkg::MAC_IDLE;
      c2_r <= sab_pkg::MAC_IDLE;
    end else begin
      c1_r <= ctl;
      c2_r <= c1_r;
    end
  end

  assign prod_ext = {{(sab_pkg::ACC_BITS - sab_pkg::PROD_BITS){prod_r[sab_pkg::PROD_BITS-1]}},
                     prod_r};

  // Multiplier stage, then accumulator stage.
  always_ff @(posedge clk) begin
    prod_r <= a * b;
    if (c1_r.first) begin
      acc_r <= prod_ext;
    end else begin
      acc_r <= acc_r + prod_ext;
    end
  end

  // Round to nearest with ties upward, then clamp to the sample range.
  assign acc_rnd = (acc_r + sab_pkg::ACC_HALF) >>> sab_pkg::COEF_FRAC_BITS;

  always_comb begin
    if (acc_rnd > sab_pkg::SAT_MAX) begin
      res = sab_pkg::SAT_MAX[sab_pkg::SAMPLE_BITS-1:0];
    end else if (acc_rnd < sab_pkg::SAT_MIN) begin
      res = sab_pkg::SAT_MIN[sab_pkg::SAMPLE_BITS-1:0];
    end else begin
      res = acc_rnd[sab_pkg::SAMPLE_BITS-1:0];
    end
  end

  assign res_dest = c2_r.last ? c2_r.dest : sab_pkg::DST_NONE;

endmodule

`default_nettype wire

### rtl/sab_dly.sv
// Right channel delay line: ring pointer, lap flag and the sample RAM.
// Depends on sab_pkg and sab_ram.
`timescale 1ns / 1ps
`default_nettype none

module sab_dly #(
  parameter int unsigned MAX_DELAY = sab_pkg::MAX_DELAY_DEFAULT,
  localparam int unsigned AW       = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1,
  localparam int unsigned LW       = $clog2(MAX_DELAY + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             clear,
  input  wire logic [LW-1:0]    len,
  input  wire logic             push,
  input  wire sab_pkg::sample_t push_data,
  input  wire logic             capture,
  output sab_pkg::sample_t      dly_out
);

  logic [AW-1:0]                  wp_r;
  logic                           full_r;
  logic [LW:0]                    wp_inc;
  logic                           wrap;
  logic [sab_pkg::SAMPLE_BITS-1:0] ram_rdata;
  sab_pkg::sample_t               dly_r;

  assign wp_inc = (LW + 1)'(wp_r) + (LW + 1)'(1);
  assign wrap   = (wp_inc >= {1'b0, len});

  // Pointer advances on each push; the lap flag marks every slot as written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      full_r <= 1'b0;
    end else if (clear) begin
      wp_r   <= '0;
      full_r <= 1'b0;
    end else if (push) begin
      wp_r <= wrap ? '0 : wp_inc[AW-1:0];
      if (wrap) begin
        full_r <= 1'b1;
      end
    end
  end

  // Slots not yet written since the last clear read as zero.
  always_ff @(posedge clk) begin
    if (capture) begin
      dly_r <= full_r ? sab_pkg::sample_t'(ram_rdata) : '0;
    end
  end

  assign dly_out = dly_r;

  sab_ram #(
    .WIDTH (sab_pkg::SAMPLE_BITS),
    .DEPTH (MAX_DELAY)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wp_r),
    .wdata (push_data),
    .raddr (wp_r),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

### rtl/sab_ctrl.sv
// Sequencer: input handshake, step counter over the multiply program, result hand-off.
// Depends on sab_pkg for states and the step program.
`timescale 1ns / 1ps
`default_nettype none

module sab_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          enable,
  input  wire logic          out_free,
  output logic               in_ready,
  output sab_pkg::seq_ctl_t  seq
);

  sab_pkg::state_t                state_r;
  sab_pkg::state_t                state_nxt;
  logic [sab_pkg::STEP_BITS-1:0]  step_r;
  logic [sab_pkg::STEP_BITS-1:0]  step_nxt;

  // State and step registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sab_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    in_ready        = 1'b0;
    seq.accept      = 1'b0;
    seq.dly_capture = 1'b0;
    seq.out_load    = 1'b0;
    seq.op          = sab_pkg::step_program(sab_pkg::STEP_BITS'(sab_pkg::NUM_STEPS));
    case (state_r)
      sab_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          seq.accept = 1'b1;
          step_nxt   = '0;
          state_nxt  = enable ? sab_pkg::ST_RUN : sab_pkg::ST_HOLD;
        end
      end
      sab_pkg::ST_RUN: begin
        seq.op          = sab_pkg::step_program(step_r);
        seq.dly_capture = (step_r == sab_pkg::STEP_BITS'(sab_pkg::DLY_CAPTURE_STEP));
        step_nxt        = step_r + sab_pkg::STEP_BITS'(1);
        if (step_r == sab_pkg::STEP_BITS'(sab_pkg::RUN_LAST)) begin
          state_nxt = sab_pkg::ST_HOLD;
        end
      end
      sab_pkg::ST_HOLD: begin
        if (out_free) begin
          seq.out_load = 1'b1;
          state_nxt    = sab_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sab_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/stereo_band_limit_haas_widener_top.sv
// Top level of the stereo band limiter with Haas widener.
// Depends on sab_pkg, sab_ctrl, sab_mac and sab_dly.
//
//   Port group | Direction | Handshake          | Transaction
//   in_        | input     | in_valid/in_ready  | one stereo frame (in_item_t)
//   out_       | output    | out_valid/out_ready| one processed frame (out_item_t)
//   cfg_       | input     | cfg_we only        | one register write, no read-back
//
// An enabled frame runs from acceptance through the 16 products of the one shared
// 24x18 multiplier in sequence, the accumulator stage with rounding and the load of
// the output register; the idle state then takes the next frame. A disabled frame
// goes from acceptance straight to the output register load.
// Reset is synchronous; filter history and the delay line read as zero afterwards,
// and the delay line also reads as zero after delay_length changes (no clearing pass).
// A result waits in the output register while the next frame is accepted; only a
// second finished frame waits for out_ready.
`timescale 1ns / 1ps
`default_nettype none

module stereo_band_limit_haas_widener_top #(
  parameter int unsigned MAX_DELAY = sab_pkg::MAX_DELAY_DEFAULT,
  localparam int unsigned LEN_BITS = $clog2(MAX_DELAY + 1)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire sab_pkg::in_item_t                     in_item,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output sab_pkg::out_item_t                         out_item,
  input  wire logic                                  cfg_we,
  input  wire logic [sab_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [sab_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  // Configuration registers.
  logic                                enable_r;
  logic [sab_pkg::GAIN_BITS-1:0]       mix_gain_r;
  logic [sab_pkg::GAIN_BITS-1:0]       hp_gain_r;
  sab_pkg::coef_t                      hp_feedback_r;
  logic [sab_pkg::GAIN_BITS-1:0]       lp_gain_r;
  sab_pkg::coef_t                      lp_feedback_r;
  logic [sab_pkg::DLEN_BITS-1:0]       delay_length_r;
  logic                                dly_clear;

  // Frame and filter history registers.
  sab_pkg::sample_t in_l_r, in_r_r;
  logic             last_r;
  sab_pkg::sample_t x1_hpl_r, x1_hpr_r, x1_lpl_r, x1_lpr_r;
  sab_pkg::sample_t y1_hpl_r, y1_hpr_r, y1_lpl_r, y1_lpr_r;
  sab_pkg::sample_t res_l_r, res_r_r;

  // Output register.
  logic               out_valid_r;
  sab_pkg::out_item_t out_item_r;

  // Datapath wiring.
  sab_pkg::seq_ctl_t             seq;
  sab_pkg::sample_t              op_a;
  sab_pkg::coef_t                op_b;
  sab_pkg::sample_t              mac_res;
  sab_pkg::dest_t                mac_dest;
  sab_pkg::sample_t              dly_out;
  sab_pkg::sample_t              wet_r;
  logic [LEN_BITS-1:0]           dly_len;
  logic                          dly_push;
  logic [sab_pkg::GAIN_BITS-1:0] mix_g;
  logic [sab_pkg::GAIN_BITS-1:0] mix_dry;
  logic                          out_free;

  // A write of a different delay length empties the delay line.
  assign dly_clear = cfg_we && (cfg_index == sab_pkg::REG_DELAY_LENGTH) &&
                     (cfg_data[sab_pkg::DLEN_BITS-1:0] != delay_length_r);

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= sab_pkg::RST_ENABLE;
      mix_gain_r     <= sab_pkg::RST_MIX_GAIN;
      hp_gain_r      <= sab_pkg::RST_HP_GAIN;
      hp_feedback_r  <= sab_pkg::RST_HP_FEEDBACK;
      lp_gain_r      <= sab_pkg::RST_LP_GAIN;
      lp_feedback_r  <= sab_pkg::RST_LP_FEEDBACK;
      delay_length_r <= sab_pkg::RST_DELAY_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        sab_pkg::REG_ENABLE:       enable_r       <= cfg_data[0];
        sab_pkg::REG_MIX_GAIN:     mix_gain_r     <= cfg_data[sab_pkg::GAIN_BITS-1:0];
        sab_pkg::REG_HP_GAIN:      hp_gain_r      <= cfg_data[sab_pkg::GAIN_BITS-1:0];
        sab_pkg::REG_HP_FEEDBACK:  hp_feedback_r  <= sab_pkg::coef_t'(cfg_data);
        sab_pkg::REG_LP_GAIN:      lp_gain_r      <= cfg_data[sab_pkg::GAIN_BITS-1:0];
        sab_pkg::REG_LP_FEEDBACK:  lp_feedback_r  <= sab_pkg::coef_t'(cfg_data);
        sab_pkg::REG_DELAY_LENGTH: delay_length_r <= cfg_data[sab_pkg::DLEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective delay length, limited to the size of the delay line.
  always_comb begin
    if (32'(delay_length_r) > 32'(MAX_DELAY)) begin
      dly_len = LEN_BITS'(MAX_DELAY);
    end else begin
      dly_len = LEN_BITS'(delay_length_r);
    end
  end

  // Wet gain limited to unity, dry gain is its complement.
  assign mix_g   = (mix_gain_r > sab_pkg::GAIN_ONE) ? sab_pkg::GAIN_ONE : mix_gain_r;
  assign mix_dry = sab_pkg::GAIN_ONE - mix_g;

  // Wet right signal: delayed, or the filtered sample when the delay is off.
  assign wet_r = (dly_len == '0) ? y1_lpr_r : dly_out;

  // Sample operand select.
  always_comb begin
    case (seq.op.opa)
      sab_pkg::OPA_IN_L:   op_a = in_l_r;
      sab_pkg::OPA_IN_R:   op_a = in_r_r;
      sab_pkg::OPA_X1_HPL: op_a = x1_hpl_r;
      sab_pkg::OPA_X1_HPR: op_a = x1_hpr_r;
      sab_pkg::OPA_X1_LPL: op_a = x1_lpl_r;
      sab_pkg::OPA_X1_LPR: op_a = x1_lpr_r;
      sab_pkg::OPA_Y1_HPL: op_a = y1_hpl_r;
      sab_pkg::OPA_Y1_HPR: op_a = y1_hpr_r;
      sab_pkg::OPA_Y1_LPL: op_a = y1_lpl_r;
      sab_pkg::OPA_Y1_LPR: op_a = y1_lpr_r;
      sab_pkg::OPA_WET_R:  op_a = wet_r;
      default:             op_a = in_l_r;
    endcase
  end

  // Coefficient operand select.
  always_comb begin
    case (seq.op.opb)
      sab_pkg::OPB_HP_B0: op_b = $signed({1'b0, hp_gain_r});
      sab_pkg::OPB_HP_B1: op_b = -$signed({1'b0, hp_gain_r});
      sab_pkg::OPB_HP_A1: op_b = hp_feedback_r;
      sab_pkg::OPB_LP_B0: op_b = $signed({1'b0, lp_gain_r});
      sab_pkg::OPB_LP_A1: op_b = lp_feedback_r;
      sab_pkg::OPB_DRY:   op_b = $signed({1'b0, mix_dry});
      sab_pkg::OPB_WET:   op_b = $signed({1'b0, mix_g});
      default:            op_b = '0;
    endcase
  end

  // Frame capture on acceptance; a disabled frame keeps its input as the result.
  always_ff @(posedge clk) begin
    if (seq.accept) begin
      in_l_r  <= in_item.left_in;
      in_r_r  <= in_item.right_in;
      last_r  <= in_item.last_frame;
      res_l_r <= in_item.left_in;
      res_r_r <= in_item.right_in;
    end else begin
      case (mac_dest)
        sab_pkg::DST_OUT_L: res_l_r <= mac_res;
        sab_pkg::DST_OUT_R: res_r_r <= mac_res;
        default: ;
      endcase
    end
  end

  // Filter history: each finished filter stores its input and output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_hpl_r <= '0;
      x1_hpr_r <= '0;
      x1_lpl_r <= '0;
      x1_lpr_r <= '0;
      y1_hpl_r <= '0;
      y1_hpr_r <= '0;
      y1_lpl_r <= '0;
      y1_lpr_r <= '0;
    end else begin
      case (mac_dest)
        sab_pkg::DST_HP_L: begin
          x1_hpl_r <= in_l_r;
          y1_hpl_r <= mac_res;
        end
        sab_pkg::DST_HP_R: begin
          x1_hpr_r <= in_r_r;
          y1_hpr_r <= mac_res;
        end
        sab_pkg::DST_LP_L: begin
          x1_lpl_r <= y1_hpl_r;
          y1_lpl_r <= mac_res;
        end
        sab_pkg::DST_LP_R: begin
          x1_lpr_r <= y1_hpr_r;
          y1_lpr_r <= mac_res;
        end
        default: ;
      endcase
    end
  end

  // The filtered right sample enters the delay line when the delay is on.
  assign dly_push = (mac_dest == sab_pkg::DST_LP_R) && (dly_len != '0);

  // Output register: loads when empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq.out_load) begin
      out_item_r.left_out       <= res_l_r;
      out_item_r.right_out      <= res_r_r;
      out_item_r.last_frame_out <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  sab_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .enable   (enable_r),
    .out_free (out_free),
    .in_ready (in_ready),
    .seq      (seq)
  );

  sab_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .a        (op_a),
    .b        (op_b),
    .ctl      (seq.op.mac),
    .res      (mac_res),
    .res_dest (mac_dest)
  );

  sab_dly #(
    .MAX_DELAY (MAX_DELAY)
  ) u_dly (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (dly_clear),
    .len       (dly_len),
    .push      (dly_push),
    .push_data (mac_res),
    .capture   (seq.dly_capture),
    .dly_out   (dly_out)
  );

endmodule

`default_nettype wire

### rtl/sab_checker.sv
// Port-level checker for the stereo band limiter top level, bound to it below.
// Depends on sab_pkg and stereo_band_limit_haas_widener_top.
`timescale 1ns / 1ps
`default_nettype none

module sab_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire sab_pkg::out_item_t out_item
);

  // After reset the block is ready for a frame and holds no result.
  a_reset_state: assert property (@(posedge clk) !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // One frame at a time: a transaction in closes the input in the cycle after it.
  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after a transaction");

  // A new result only appears while a frame is being worked on.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

endmodule

bind stereo_band_limit_haas_widener_top sab_checker u_sab_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

### tb/sv/tb_stereo_band_limit_haas_widener_top.sv
// Self-checking testbench for stereo_band_limit_haas_widener_top.
// Depends on sab_pkg and the block's RTL; a scoreboard class predicts every frame,
// and plain tasks drive frames and register writes with random pacing; an always block adds output stalls.
`timescale 1ns / 1ps

module tb_stereo_band_limit_haas_widener_top;
  import sab_pkg::*;

  localparam int unsigned    DELAY_DEPTH   = MAX_DELAY_DEFAULT;
  localparam longint         UNITY         = 64'sd1 << COEF_FRAC_BITS;
  localparam longint         ROUND_HALF    = UNITY >>> 1;
  localparam longint         SAMPLE_HI     = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam longint         SAMPLE_LO     = -SAMPLE_HI - 64'sd1;
  localparam sample_t        SAMPLE_TOP    = 24'h7FFFFF;
  localparam sample_t        SAMPLE_BOTTOM = 24'h800000;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned    RANDOM_FRAMES = 800;
  localparam int unsigned    SETTLE_CYCLES = 40;
  localparam int unsigned    CYCLE_LIMIT   = 600000;
  localparam int unsigned    MAX_REPORTS   = 10;

  // Filter history slots.
  localparam int SLOT_HP_L = 0;
  localparam int SLOT_HP_R = 1;
  localparam int SLOT_LP_L = 2;
  localparam int SLOT_LP_R = 3;

  // Predicts each accepted frame and checks results in order.
  class widener_scoreboard;
    bit                        enabled;
    int unsigned               mix_gain;
    int unsigned               hp_gain;
    int                        hp_feedback;
    int unsigned               lp_gain;
    int                        lp_feedback;
    int unsigned               delay_len;
    int                        prev_x[4];
    int                        prev_y[4];
    int                        delay_line[DELAY_DEPTH];
    int unsigned               write_ptr;
    out_item_t                 expected_frames[$];
    int unsigned               mismatches;

    function new();
      enabled     = RST_ENABLE;
      mix_gain    = RST_MIX_GAIN;
      hp_gain     = RST_HP_GAIN;
      hp_feedback = RST_HP_FEEDBACK;
      lp_gain     = RST_LP_GAIN;
      lp_feedback = RST_LP_FEEDBACK;
      delay_len   = RST_DELAY_LENGTH;
      mismatches  = 0;
      foreach (prev_x[i]) begin
        prev_x[i] = 0;
        prev_y[i] = 0;
      end
      clear_delay();
    endfunction

    function void clear_delay();
      foreach (delay_line[i]) delay_line[i] = 0;
      write_ptr = 0;
    endfunction

    function int unsigned pending();
      return expected_frames.size();
    endfunction

    // Mirrors one register write; unknown indexes are ignored.
    function void note_config(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_ENABLE:      enabled = data[0];
        REG_MIX_GAIN:    mix_gain = data[GAIN_BITS-1:0];
        REG_HP_GAIN:     hp_gain = data[GAIN_BITS-1:0];
        REG_HP_FEEDBACK: hp_feedback = int'($signed(data[COEF_BITS-1:0]));
        REG_LP_GAIN:     lp_gain = data[GAIN_BITS-1:0];
        REG_LP_FEEDBACK: lp_feedback = int'($signed(data[COEF_BITS-1:0]));
        REG_DELAY_LENGTH: begin
          // A new length restarts the delay line from silence.
          if (data[DLEN_BITS-1:0] != delay_len) begin
            delay_len = data[DLEN_BITS-1:0];
            clear_delay();
          end
        end
        default: ;
      endcase
    endfunction

    // Round to nearest with ties upward, then clamp to the sample range.
    function int round_clamp(longint acc);
      longint r;
      r = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
      if (r > SAMPLE_HI) r = SAMPLE_HI;
      else if (r < SAMPLE_LO) r = SAMPLE_LO;
      return int'(r);
    endfunction

    function int filter_step(int slot, int x, longint b0, longint b1, longint a1);
      longint acc;
      int     y;
      acc = b0 * x + b1 * prev_x[slot] + a1 * prev_y[slot];
      y = round_clamp(acc);
      prev_x[slot] = x;
      prev_y[slot] = y;
      return y;
    endfunction

    function int crossfade(int dry, int wet);
      longint g;
      g = (mix_gain > UNITY) ? UNITY : longint'(mix_gain);
      return round_clamp(longint'(dry) * (UNITY - g) + longint'(wet) * g);
    endfunction

    // Works out the result of one accepted frame and queues it.
    function void note_frame(in_item_t f);
      int          dry_l;
      int          dry_r;
      int          band_l;
      int          band_r;
      int          wet_r;
      int          res_l;
      int          res_r;
      int unsigned len;
      int unsigned wp;
      out_item_t   want;
      dry_l = int'($signed(f.left_in));
      dry_r = int'($signed(f.right_in));
      res_l = dry_l;
      res_r = dry_r;
      if (enabled) begin
        len = (delay_len > DELAY_DEPTH) ? DELAY_DEPTH : delay_len;
        band_l = filter_step(SLOT_HP_L, dry_l, hp_gain, -longint'(hp_gain), hp_feedback);
        band_r = filter_step(SLOT_HP_R, dry_r, hp_gain, -longint'(hp_gain), hp_feedback);
        band_l = filter_step(SLOT_LP_L, band_l, lp_gain, lp_gain, lp_feedback);
        band_r = filter_step(SLOT_LP_R, band_r, lp_gain, lp_gain, lp_feedback);
        wet_r = band_r;
        if (len > 0) begin
          wp = write_ptr;
          if (wp >= len) wp = 0;
          wet_r = delay_line[wp];
          delay_line[wp] = band_r;
          wp++;
          if (wp >= len) wp = 0;
          write_ptr = wp;
        end
        res_l = crossfade(dry_l, band_l);
        res_r = crossfade(dry_r, wet_r);
      end
      want.left_out       = sample_t'(res_l);
      want.right_out      = sample_t'(res_r);
      want.last_frame_out = f.last_frame;
      expected_frames.push_back(want);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // Compares one delivered frame with the oldest prediction.
    function void check_frame(out_item_t got);
      out_item_t want;
      if (expected_frames.size() == 0) begin
        report($sformatf("Unexpected frame: left %0d right %0d last %0b",
                         got.left_out, got.right_out, got.last_frame_out));
        return;
      end
      want = expected_frames.pop_front();
      if (got.left_out !== want.left_out)
        report($sformatf("left_out mismatch: expected %0d, got %0d",
                         want.left_out, got.left_out));
      if (got.right_out !== want.right_out)
        report($sformatf("right_out mismatch: expected %0d, got %0d",
                         want.right_out, got.right_out));
      if (got.last_frame_out !== want.last_frame_out)
        report($sformatf("last_frame_out mismatch: expected %0b, got %0b",
                         want.last_frame_out, got.last_frame_out));
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  in_item_t                  in_item = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_item_t                 out_item;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  widener_scoreboard sb;
  int unsigned       burst_left = 1;
  bit                steady_phase = 1'b0;
  int unsigned       cycles_run = 0;
  logic [6:0]        stall_phase = '0;
  logic [1:0]        stall_mode = '0;

  stereo_band_limit_haas_widener_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Result side: check every delivered transaction and stall on a changing pattern.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_frame(out_item);
    stall_phase <= stall_phase + 7'd1;
    if (stall_phase == '0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_phase[3:2] != 2'b11);
    endcase
  end

  // Watchdog on the total run length.
  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Holds the frame until it is accepted, then records it for prediction.
  task automatic send_frame(in_item_t f);
    in_item  <= f;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_frame(f);
  endtask

  task automatic idle_gap(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Bursts of back-to-back frames separated by random gaps.
  task automatic pace_sender();
    if (steady_phase) return;
    burst_left--;
    if (burst_left == 0) begin
      idle_gap($urandom_range(1, 12));
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // Stops sending until every predicted frame has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Leaves the write enable high so that consecutive writes run back to back.
  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.note_config(idx, data);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t make_frame(sample_t l, sample_t r, logic last);
    in_item_t f;
    f.left_in    = l;
    f.right_in   = r;
    f.last_frame = last;
    return f;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_TOP;
      1:       return SAMPLE_BOTTOM;
      2:       return '0;
      3, 4:    return sample_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_BITS'(GAIN_ONE);
      2:       return CFG_DATA_BITS'($urandom_range(0, 131071));
      default: return CFG_DATA_BITS'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_feedback();
    case ($urandom_range(0, 9))
      0:       return CFG_DATA_BITS'(-65536);
      1:       return CFG_DATA_BITS'(65536);
      2:       return CFG_DATA_BITS'($urandom);
      3:       return $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
      default: return CFG_DATA_BITS'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_delay(int unsigned held);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_BITS'(DELAY_DEPTH);
      2:       return CFG_DATA_BITS'(12'hFFF);
      3:       return CFG_DATA_BITS'(held);
      4:       return CFG_DATA_BITS'($urandom_range(0, 4095));
      default: return CFG_DATA_BITS'($urandom_range(1, 40));
    endcase
  endfunction

  // New random settings for a phase; each register is rewritten with some chance.
  task automatic randomize_settings();
    logic en;
    en = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 3) != 0) write_reg(REG_ENABLE, {17'($urandom), en});
    if ($urandom_range(0, 3) != 0) write_reg(REG_MIX_GAIN, pick_gain());
    if ($urandom_range(0, 3) != 0) write_reg(REG_HP_GAIN, pick_gain());
    if ($urandom_range(0, 3) != 0) write_reg(REG_HP_FEEDBACK, pick_feedback());
    if ($urandom_range(0, 3) != 0) write_reg(REG_LP_GAIN, pick_gain());
    if ($urandom_range(0, 3) != 0) write_reg(REG_LP_FEEDBACK, pick_feedback());
    if ($urandom_range(0, 3) != 0) write_reg(REG_DELAY_LENGTH, pick_delay(sb.delay_len));
    if ($urandom_range(0, 15) == 0) write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
    end_writes();
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    in_item_t    f;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled after reset: frames pass through untouched.
    send_frame(make_frame(SAMPLE_TOP, SAMPLE_BOTTOM, 1'b1));
    send_frame(make_frame(SAMPLE_BOTTOM, SAMPLE_TOP, 1'b0));
    send_frame(make_frame('0, '1, 1'b1));
    drain();

    // Fully wet, no delay; unity low-pass doubles and saturates.
    write_reg(REG_ENABLE, 18'h3FFF1);
    write_reg(REG_MIX_GAIN, CFG_DATA_BITS'(GAIN_ONE));
    write_reg(REG_HP_GAIN, CFG_DATA_BITS'(GAIN_ONE));
    write_reg(REG_HP_FEEDBACK, '0);
    write_reg(REG_LP_GAIN, CFG_DATA_BITS'(GAIN_ONE));
    write_reg(REG_LP_FEEDBACK, '0);
    write_reg(REG_DELAY_LENGTH, '0);
    end_writes();
    send_frame(make_frame(SAMPLE_TOP, SAMPLE_TOP, 1'b0));
    send_frame(make_frame(SAMPLE_BOTTOM, SAMPLE_BOTTOM, 1'b0));
    send_frame(make_frame(SAMPLE_TOP, SAMPLE_BOTTOM, 1'b1));
    send_frame(make_frame('0, '0, 1'b0));
    drain();

    // Gain above unity, extreme feedback and a short delay.
    write_reg(REG_MIX_GAIN, 18'h1FFFF);
    write_reg(REG_HP_GAIN, 18'h1FFFF);
    write_reg(REG_HP_FEEDBACK, 18'h1FFFF);
    write_reg(REG_LP_FEEDBACK, 18'h20000);
    write_reg(REG_DELAY_LENGTH, 18'd3);
    end_writes();
    send_frame(make_frame(SAMPLE_TOP, SAMPLE_BOTTOM, 1'b0));
    send_frame(make_frame(24'sd1000, -24'sd1000, 1'b0));
    send_frame(make_frame(SAMPLE_BOTTOM, SAMPLE_TOP, 1'b1));
    send_frame(make_frame('0, 24'sd12345, 1'b0));
    send_frame(make_frame(-24'sd1, 24'sd1, 1'b1));
    drain();

    // Same delay length again keeps the line; a dry mix.
    write_reg(REG_DELAY_LENGTH, 18'd3);
    write_reg(REG_MIX_GAIN, '0);
    end_writes();
    send_frame(make_frame(24'sd777, SAMPLE_TOP, 1'b0));
    send_frame(make_frame(SAMPLE_BOTTOM, -24'sd5, 1'b1));
    drain();

    // Length beyond the line depth, and a write to an unused index.
    write_reg(REG_DELAY_LENGTH, 18'hFFF);
    write_reg(REG_MIX_GAIN, 18'd32768);
    write_reg(REG_UNUSED, 18'h3FFFF);
    end_writes();
    send_frame(make_frame(SAMPLE_TOP, SAMPLE_TOP, 1'b0));
    send_frame(make_frame(24'sd4096, -24'sd4096, 1'b1));
    drain();

    // Disabling holds all state; enabling resumes from it.
    write_reg(REG_ENABLE, 18'h3FFFE);
    end_writes();
    send_frame(make_frame(24'sd42, -24'sd42, 1'b0));
    send_frame(make_frame(SAMPLE_BOTTOM, SAMPLE_TOP, 1'b1));
    drain();
    write_reg(REG_ENABLE, 18'h00001);
    end_writes();
    send_frame(make_frame(-24'sd300000, 24'sd300000, 1'b0));
    send_frame(make_frame(SAMPLE_TOP, '0, 1'b1));
    drain();

    // Random phases: new settings while idle, then paced random frames.
    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      randomize_settings();
      steady_phase = ($urandom_range(0, 3) == 0);
      burst_left   = $urandom_range(1, 16);
      phase_len    = $urandom_range(10, 60);
      repeat (phase_len) begin
        f = make_frame(pick_sample(), pick_sample(), ($urandom_range(0, 7) == 0));
        send_frame(f);
        sent++;
        if ($urandom_range(0, 63) == 0) drain();
        else pace_sender();
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
